@@ rtl/core/blru_pkg.sv @@
package blru_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ID_W    = 64;
    localparam int SIZE_W  = 32;
    localparam int BYTES_W = 40;

    localparam logic [BYTES_W-1:0] CAP_RESET = 40'd1048576;

    localparam logic [1:0] OP_ACCESS = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_EVICT  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_ABSENT    = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam logic KIND_EVICT = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef struct packed {
        logic       load;
        logic       lookup;
        logic       sel_old;
        logic       touch;
        logic       drop;
        logic       insert;
        logic       emit;
        logic       kind;
        logic [2:0] status;
        logic       victim;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       hit;
        logic       size_zero;
        logic       too_large;
        logic       full;
        logic       empty;
        logic       over;
        logic       out_free;
    } dp_stat_t;

endpackage

@@ rtl/core/blru_if.sv @@
interface blru_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     opcode;
    logic [blru_pkg::ID_W-1:0]      object_id;
    logic [blru_pkg::SIZE_W-1:0]    object_size;
    modport source (output valid, opcode, object_id, object_size, input ready);
    modport sink (input valid, opcode, object_id, object_size, output ready);
endinterface

interface blru_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [blru_pkg::ID_W-1:0]      victim_id;
    logic [blru_pkg::SIZE_W-1:0]    victim_size;
    logic                           hit;
    logic [2:0]                     status;
    logic [blru_pkg::BYTES_W-1:0]   bytes_in_use;
    logic                           last;
    modport source (output valid, kind, victim_id, victim_size, hit, status,
                    bytes_in_use, last, input ready);
    modport sink (input valid, kind, victim_id, victim_size, hit, status,
                  bytes_in_use, last, output ready);
endinterface

interface blru_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [blru_pkg::BYTES_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/blru_dp.sv @@
module blru_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  blru_pkg::dp_cmd_t              cmd,
    output blru_pkg::dp_stat_t             stat,
    input  logic [1:0]                     opcode,
    input  logic [blru_pkg::ID_W-1:0]      object_id,
    input  logic [blru_pkg::SIZE_W-1:0]    object_size,
    input  logic                           cfg_valid,
    input  logic [blru_pkg::BYTES_W-1:0]   cfg_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic                           rsp_kind,
    output logic [blru_pkg::ID_W-1:0]      rsp_victim_id,
    output logic [blru_pkg::SIZE_W-1:0]    rsp_victim_size,
    output logic                           rsp_hit,
    output logic [2:0]                     rsp_status,
    output logic [blru_pkg::BYTES_W-1:0]   rsp_bytes_in_use,
    output logic                           rsp_last
);
    import blru_pkg::*;

    logic [1:0]         op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   tgt_reg;
    logic [BYTES_W-1:0] cap_reg;
    logic [BYTES_W-1:0] used_reg;
    logic [BYTES_W-1:0] used_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ID_W-1:0]    sid_reg   [ENTRIES];
    logic [SIZE_W-1:0]  sbytes_reg[ENTRIES];
    logic [IDX_W-1:0]   rank_reg  [ENTRIES];

    logic               ov_reg;
    logic               okind_reg;
    logic [ID_W-1:0]    ovid_reg;
    logic [SIZE_W-1:0]  ovsz_reg;
    logic               ohit_reg;
    logic [2:0]         ostat_reg;
    logic [BYTES_W-1:0] oused_reg;

    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   old_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [CNT_W-1:0]   cnt_m1;
    logic [ID_W-1:0]    t_id;
    logic [SIZE_W-1:0]  t_bytes;
    logic [IDX_W-1:0]   t_rank;
    logic [BYTES_W-1:0] t_bytes_ext;
    logic [BYTES_W-1:0] size_ext;
    logic [BYTES_W-1:0] used_sub;
    logic               out_free;

    assign cnt_m1      = cnt_reg - CNT_W'(1);
    assign t_id        = sid_reg[tgt_reg];
    assign t_bytes     = sbytes_reg[tgt_reg];
    assign t_rank      = rank_reg[tgt_reg];
    assign t_bytes_ext = BYTES_W'(t_bytes);
    assign size_ext    = BYTES_W'(size_reg);
    assign used_sub    = (used_reg >= t_bytes_ext) ? used_reg - t_bytes_ext : '0;
    assign out_free    = !ov_reg || rsp_ready;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        old_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && sid_reg[i] == id_reg)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (valid_reg[i] && CNT_W'(rank_reg[i]) == cnt_m1)
                old_idx = IDX_W'(i);
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.touch)
            used_next = used_sub + size_ext;
        else if (cmd.drop)
            used_next = used_sub;
        else if (cmd.insert)
            used_next = used_reg + size_ext;
    end

    always_comb
    begin
        stat.op        = op_reg;
        stat.hit       = hit_reg;
        stat.size_zero = (size_reg == '0);
        stat.too_large = (size_ext > cap_reg);
        stat.full      = (cnt_reg == CNT_W'(ENTRIES));
        stat.empty     = (cnt_reg == '0);
        stat.over      = (used_reg > cap_reg);
        stat.out_free  = out_free;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            used_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                cap_reg <= cfg_data;
            used_reg <= used_next;
            if (cmd.drop)
            begin
                valid_reg[tgt_reg] <= 1'b0;
                cnt_reg            <= cnt_reg - CNT_W'(1);
            end
            else if (cmd.insert)
            begin
                valid_reg[free_idx] <= 1'b1;
                cnt_reg             <= cnt_reg + CNT_W'(1);
            end
            if (cmd.emit)
                ov_reg <= 1'b1;
            else if (rsp_ready)
                ov_reg <= 1'b0;
        end
    end

    // slot payload and recency ranks
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            id_reg   <= object_id;
            size_reg <= object_size;
        end
        if (cmd.lookup)
        begin
            hit_reg <= hit_any;
            tgt_reg <= hit_idx;
        end
        if (cmd.sel_old)
            tgt_reg <= old_idx;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cmd.touch && valid_reg[i] && rank_reg[i] < t_rank)
                rank_reg[i] <= rank_reg[i] + IDX_W'(1);
            if (cmd.drop && valid_reg[i] && rank_reg[i] > t_rank)
                rank_reg[i] <= rank_reg[i] - IDX_W'(1);
            if (cmd.insert && valid_reg[i])
                rank_reg[i] <= rank_reg[i] + IDX_W'(1);
        end
        if (cmd.touch)
        begin
            sbytes_reg[tgt_reg] <= size_reg;
            rank_reg[tgt_reg]   <= '0;
        end
        if (cmd.insert)
        begin
            sid_reg[free_idx]    <= id_reg;
            sbytes_reg[free_idx] <= size_reg;
            rank_reg[free_idx]   <= '0;
        end
        if (cmd.emit)
        begin
            okind_reg <= cmd.kind;
            ovid_reg  <= cmd.victim ? t_id : '0;
            ovsz_reg  <= cmd.victim ? t_bytes : '0;
            ohit_reg  <= (op_reg == OP_ACCESS) ? hit_reg : 1'b0;
            ostat_reg <= cmd.status;
            oused_reg <= used_next;
        end
    end

    assign rsp_valid        = ov_reg;
    assign rsp_kind         = okind_reg;
    assign rsp_victim_id    = ovid_reg;
    assign rsp_victim_size  = ovsz_reg;
    assign rsp_hit          = ohit_reg;
    assign rsp_status       = ostat_reg;
    assign rsp_bytes_in_use = oused_reg;
    assign rsp_last         = okind_reg;

endmodule

@@ rtl/core/blru_ctrl.sv @@
module blru_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  blru_pkg::dp_stat_t  stat,
    output blru_pkg::dp_cmd_t   cmd
);
    import blru_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOOK = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_SEL  = 4'd3;
    localparam logic [3:0] S_DROP = 4'd4;
    localparam logic [3:0] S_INS  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_REM  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             fill_reg, fill_next;
    logic [2:0]       fstat_reg, fstat_next;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        fill_next  = fill_reg;
        fstat_next = fstat_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    k_next     = '0;
                    fill_next  = 1'b0;
                    fstat_next = ST_OK;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                case (stat.op)
                    OP_ACCESS:
                    begin
                        if (stat.size_zero)
                        begin
                            fstat_next = ST_ZERO;
                            state_next = S_FIN;
                        end
                        else if (stat.too_large)
                        begin
                            fstat_next = ST_TOO_LARGE;
                            state_next = S_FIN;
                        end
                        else if (stat.hit)
                        begin
                            cmd.touch  = 1'b1;
                            state_next = S_CHK;
                        end
                        else if (stat.full)
                        begin
                            fill_next  = 1'b1;
                            state_next = S_SEL;
                        end
                        else
                            state_next = S_INS;
                    end
                    OP_REMOVE:
                    begin
                        if (stat.hit)
                            state_next = S_REM;
                        else
                        begin
                            fstat_next = ST_ABSENT;
                            state_next = S_FIN;
                        end
                    end
                    OP_EVICT:
                    begin
                        if (stat.empty)
                        begin
                            fstat_next = ST_EMPTY;
                            state_next = S_FIN;
                        end
                        else
                            state_next = S_SEL;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_SEL:
            begin
                cmd.sel_old = 1'b1;
                state_next  = S_DROP;
            end
            S_DROP:
            begin
                if (stat.out_free)
                begin
                    cmd.drop   = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.victim = 1'b1;
                    cmd.status = ST_OK;
                    if (stat.op == OP_EVICT)
                    begin
                        cmd.kind   = KIND_FINAL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.kind = KIND_EVICT;
                        k_next   = k_reg + CNT_W'(1);
                        if (fill_reg)
                        begin
                            fill_next  = 1'b0;
                            state_next = S_INS;
                        end
                        else
                            state_next = S_CHK;
                    end
                end
            end
            S_INS:
            begin
                cmd.insert = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.over && k_reg < CNT_W'(ENTRIES) && !stat.empty)
                    state_next = S_SEL;
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_FINAL;
                    cmd.status = fstat_reg;
                    state_next = S_IDLE;
                end
            end
            S_REM:
            begin
                if (stat.out_free)
                begin
                    cmd.drop   = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.victim = 1'b1;
                    cmd.kind   = KIND_FINAL;
                    cmd.status = ST_OK;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            fill_reg  <= 1'b0;
            fstat_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            fill_reg  <= fill_next;
            fstat_reg <= fstat_next;
        end
    end

endmodule

@@ rtl/core/byte_capacity_lru_cache.sv @@
// Sequence: an accepted transaction is loaded, looked up and decoded; a status-only result
// or a remove is then reported, an evict-oldest selects, drops and reports the oldest slot,
// and a hit updates its slot or an insert fills a free slot before capacity is rechecked;
// a slot-full eviction comes before the insert, and each capacity eviction selects the
// oldest, drops and reports it and rechecks. One transaction at a time; responses can stall.
// Reset: async active low; all slots invalid, bytes in use zero, capacity 1048576.
module byte_capacity_lru_cache (
    input  logic         clk,
    input  logic         rst_n,
    blru_req_if.sink     req,
    blru_rsp_if.source   rsp,
    blru_cfg_if.sink     cfg
);
    import blru_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    blru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    blru_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .opcode           (req.opcode),
        .object_id        (req.object_id),
        .object_size      (req.object_size),
        .cfg_valid        (cfg.valid),
        .cfg_data         (cfg.data),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_kind         (rsp.kind),
        .rsp_victim_id    (rsp.victim_id),
        .rsp_victim_size  (rsp.victim_size),
        .rsp_hit          (rsp.hit),
        .rsp_status       (rsp.status),
        .rsp_bytes_in_use (rsp.bytes_in_use),
        .rsp_last         (rsp.last)
    );

endmodule
